### design/bced_pkg.sv
// shared types and constants for the button click event detector
// no dependencies; used by bced_regs, bced_update and the top level
package bced_pkg;

  // per-button state machine, one-hot coded
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_PRESSED  = 8'b0000_0010,
    ST_RELEASED = 8'b0000_0100,
    ST_CLICK    = 8'b0000_1000,
    ST_LONG     = 8'b0001_0000,
    ST_LONG_END = 8'b0010_0000,
    ST_DOUBLE   = 8'b0100_0000,
    ST_WAIT     = 8'b1000_0000
  } bced_state_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CLICK  = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_LONG   = 2'd3
  } bced_kind_t;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_ACTIVE_LEVEL  = 2'd0,
    REG_LONG_PRESS    = 2'd1,
    REG_DOUBLE_WINDOW = 2'd2,
    REG_MIN_PRESS     = 2'd3
  } bced_reg_t;

  localparam logic        ACTIVE_LEVEL_RST  = 1'b0;
  localparam logic [15:0] LONG_PRESS_RST    = 16'd1000;
  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd300;
  localparam logic [15:0] MIN_PRESS_RST     = 16'd20;

  typedef struct packed {
    logic        active_level;
    logic [15:0] long_press_ticks;
    logic [15:0] double_click_window;
    logic [15:0] min_press_ticks;
  } bced_cfg_t;

  // one memory word per button
  typedef struct packed {
    bced_state_t state;
    logic [31:0] press_start;
    logic [31:0] release_time;
  } bced_entry_t;

  localparam bced_entry_t ENTRY_RST = '{state: ST_IDLE, press_start: 32'd0,
                                        release_time: 32'd0};

endpackage

### design/bced_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bced_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/bced_regs.sv
// apb-style configuration registers of the button event detector
// depends on bced_pkg
module bced_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bced_pkg::bced_cfg_t cfg
);

  bced_pkg::bced_cfg_t cfg_r;
  bced_pkg::bced_cfg_t cfg_nxt;
  bced_pkg::bced_reg_t sel;
  logic                wr;

  assign sel   = bced_pkg::bced_reg_t'(paddr[3:2]);
  assign wr    = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (sel)
        bced_pkg::REG_ACTIVE_LEVEL:  cfg_nxt.active_level        = pwdata[0];
        bced_pkg::REG_LONG_PRESS:    cfg_nxt.long_press_ticks    = pwdata[15:0];
        bced_pkg::REG_DOUBLE_WINDOW: cfg_nxt.double_click_window = pwdata[15:0];
        bced_pkg::REG_MIN_PRESS:     cfg_nxt.min_press_ticks     = pwdata[15:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      bced_pkg::REG_ACTIVE_LEVEL:  prdata = {31'd0, cfg_r.active_level};
      bced_pkg::REG_LONG_PRESS:    prdata = {16'd0, cfg_r.long_press_ticks};
      bced_pkg::REG_DOUBLE_WINDOW: prdata = {16'd0, cfg_r.double_click_window};
      bced_pkg::REG_MIN_PRESS:     prdata = {16'd0, cfg_r.min_press_ticks};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level        <= bced_pkg::ACTIVE_LEVEL_RST;
      cfg_r.long_press_ticks    <= bced_pkg::LONG_PRESS_RST;
      cfg_r.double_click_window <= bced_pkg::DOUBLE_WINDOW_RST;
      cfg_r.min_press_ticks     <= bced_pkg::MIN_PRESS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/bced_update.sv
// next-state and event logic for one button entry
// depends on bced_pkg
module bced_update (
  input  bced_pkg::bced_cfg_t   cfg,
  input  bced_pkg::bced_entry_t cur,
  input  logic                  pressed,
  input  logic [31:0]           now_ticks,
  output bced_pkg::bced_entry_t nxt,
  output bced_pkg::bced_kind_t  kind
);

  logic [31:0] held;
  logic [31:0] since_rel;
  logic [31:0] press_len;
  logic [31:0] long_lim;
  logic [31:0] win;
  logic [31:0] min_lim;

  assign held      = now_ticks - cur.press_start;
  assign since_rel = now_ticks - cur.release_time;
  assign press_len = cur.release_time - cur.press_start;
  assign long_lim  = {16'd0, cfg.long_press_ticks};
  assign win       = {16'd0, cfg.double_click_window};
  assign min_lim   = {16'd0, cfg.min_press_ticks};

  always_comb begin
    nxt  = cur;
    kind = bced_pkg::KIND_NONE;
    unique case (cur.state)
      bced_pkg::ST_IDLE: begin
        if (pressed) begin
          nxt.state       = bced_pkg::ST_PRESSED;
          nxt.press_start = now_ticks;
        end
      end
      bced_pkg::ST_PRESSED: begin
        if (!pressed) begin
          nxt.state        = bced_pkg::ST_RELEASED;
          nxt.release_time = now_ticks;
        end else if (held > long_lim) begin
          nxt.state = bced_pkg::ST_LONG;
        end
      end
      bced_pkg::ST_LONG: begin
        if (!pressed) begin
          nxt.state = bced_pkg::ST_LONG_END;
        end
      end
      bced_pkg::ST_RELEASED: begin
        if (pressed && since_rel < win) begin
          nxt.state = bced_pkg::ST_DOUBLE;
        end else if (since_rel > win) begin
          // too-short press drops back to idle without an event
          nxt.state = (press_len > min_lim) ? bced_pkg::ST_CLICK : bced_pkg::ST_IDLE;
        end
      end
      bced_pkg::ST_CLICK: begin
        kind      = bced_pkg::KIND_CLICK;
        nxt.state = bced_pkg::ST_WAIT;
      end
      bced_pkg::ST_DOUBLE: begin
        kind      = bced_pkg::KIND_DOUBLE;
        nxt.state = bced_pkg::ST_WAIT;
      end
      bced_pkg::ST_LONG_END: begin
        kind      = bced_pkg::KIND_LONG;
        nxt.state = bced_pkg::ST_WAIT;
      end
      bced_pkg::ST_WAIT: begin
        if (!pressed) begin
          nxt.state = bced_pkg::ST_IDLE;
        end
      end
      default: begin
        nxt.state = bced_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/button_click_event_detector_unit.sv
// button click / double click / long press detector, top level
// a polled word goes to the s1 registers, then to the output registers
// throughput: one poll per cycle unless stalled; per-button state sits
//   in one ram, read at accept, written back when s1 fires, forwarded
// reset: per-entry valid flops clear at once, so no clearing pass is needed
// depends on bced_pkg, bced_ram, bced_regs, bced_update
module button_click_event_detector_unit #(
  parameter int NUM_BUTTONS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_button_index,
  input  logic        in_pin_level,
  input  logic [31:0] in_now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_button,
  output logic [1:0]  out_event_kind
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int EW = $bits(bced_pkg::bced_entry_t);

  bced_pkg::bced_cfg_t   cfg;
  bced_pkg::bced_entry_t rd_entry;
  bced_pkg::bced_entry_t cur_entry;
  bced_pkg::bced_entry_t new_entry;
  bced_pkg::bced_kind_t  kind;
  logic [EW-1:0]         ram_rdata;

  logic                   in_fire;
  logic                   s1_fire;
  logic                   s1_in_range;
  logic                   we;
  logic [AW-1:0]          waddr;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [3:0]             s1_idx_r;
  logic                   s1_pressed_r;
  logic [31:0]            s1_now_r;
  logic                   fwd_hit_r;
  bced_pkg::bced_entry_t  fwd_data_r;
  logic [NUM_BUTTONS-1:0] ent_valid_r, ent_valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [3:0]             out_button_r;
  logic [1:0]             out_kind_r;

  bced_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign s1_in_range = {1'b0, s1_idx_r} < 5'(NUM_BUTTONS);
  assign we          = s1_fire && s1_in_range;
  assign waddr       = s1_idx_r[AW-1:0];

  bced_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (new_entry),
    .re    (in_fire),
    .raddr (in_button_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry = bced_pkg::bced_entry_t'(ram_rdata);

  // the write-back at the accept edge is newer than what the ram returned
  always_comb begin
    priority if (fwd_hit_r) begin
      cur_entry = fwd_data_r;
    end else if (ent_valid_r[waddr]) begin
      cur_entry = rd_entry;
    end else begin
      cur_entry = bced_pkg::ENTRY_RST;
    end
  end

  bced_update u_update (
    .cfg       (cfg),
    .cur       (cur_entry),
    .pressed   (s1_pressed_r),
    .now_ticks (s1_now_r),
    .nxt       (new_entry),
    .kind      (kind)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    ent_valid_nxt = ent_valid_r;
    if (we) begin
      ent_valid_nxt[waddr] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ent_valid_r <= '0;
      fwd_hit_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ent_valid_r <= ent_valid_nxt;
      if (in_fire) begin
        fwd_hit_r <= we && (waddr == in_button_index[AW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r     <= in_button_index;
      s1_pressed_r <= (in_pin_level == cfg.active_level);
      s1_now_r     <= in_now_ticks;
      fwd_data_r   <= new_entry;
    end
    if (s1_fire) begin
      out_button_r <= s1_idx_r;
      out_kind_r   <= s1_in_range ? kind : bced_pkg::KIND_NONE;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_button = out_button_r;
  assign out_event_kind   = out_kind_r;

endmodule
